// File: rtl/core/bhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, constants and helpers of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // child index math: 2*i+2 for any i below CAPACITY
   localparam int CIDX_W   = ADDR_W + 2;
   localparam int PRIO_W   = 16;
   localparam int TAG_W    = 16;
   localparam int OCC_W    = 7;
   localparam int ENTRY_W  = PRIO_W + TAG_W;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [CIDX_W-1:0] cidx_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [PRIO_W-1:0] priority_req;
      logic [TAG_W-1:0]  payload;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [PRIO_W-1:0] top_priority;
      logic [TAG_W-1:0]  top_payload;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic      we;
      addr_type  waddr;
      entry_type wdata;
      addr_type  raddr_a;
      addr_type  raddr_b;
   } mem_req_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_DOWN_LOAD,
      ST_DOWN,
      ST_PLACE,
      ST_PEEK,
      ST_RESP
   } state_type;

   function automatic addr_type parent_of(addr_type c);
      addr_type d;
      d = c - addr_type'(1);
      return d >> 1;
   endfunction

   function automatic cidx_type left_of(addr_type p);
      return {1'b0, p, 1'b1};
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/bhpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule
`default_nettype wire

// File: rtl/core/bhpq_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_engine
// Heap sequencer: runs insert sift-up, remove sift-down and peek against the
// heap memory, one tree level per cycle, and holds the entry count.
// ----------------------------------------------------------------------------
module bhpq_engine
   import bhpq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire req_type        req,
   input  wire logic           slot_free,
   output      eng_status_type status,
   output      rsp_type        result,
   output      mem_req_type    mem_req,
   input  wire entry_type      rd_a,
   input  wire entry_type      rd_b
);

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   addr_type  pos_ff, pos_in;
   entry_type moving_ff, moving_in;
   rsp_type   res_ff, res_in;

   // sift-up view
   addr_type  up_parent;
   logic      up_stop;
   // sift-down view
   cidx_type  dn_left, dn_right, ch_left, cnt_ext;
   logic      use_right, down_stop, ch_has_child;
   entry_type chosen;
   addr_type  chosen_idx;

   logic      not_full, not_empty;

   assign not_full  = count_ff < count_type'(CAPACITY);
   assign not_empty = count_ff != '0;
   assign cnt_ext   = cidx_type'(count_ff);

   assign up_parent = parent_of(pos_ff);
   assign up_stop   = rd_a.prio > moving_ff.prio;

   assign dn_left      = left_of(pos_ff);
   assign dn_right     = dn_left + cidx_type'(1);
   assign use_right    = (dn_right < cnt_ext) && (rd_a.prio < rd_b.prio);
   assign chosen       = use_right ? rd_b : rd_a;
   assign chosen_idx   = use_right ? dn_right[ADDR_W-1:0] : dn_left[ADDR_W-1:0];
   assign down_stop    = moving_ff.prio >= chosen.prio;
   assign ch_left      = left_of(chosen_idx);
   assign ch_has_child = ch_left < cnt_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req.operation)
                  OP_INSERT: begin
                     if (!not_full) state_in = ST_RESP;
                     else if (!not_empty) state_in = ST_PLACE;
                     else state_in = ST_UP;
                  end
                  OP_REMOVE: state_in = not_empty ? ST_DOWN_LOAD : ST_RESP;
                  OP_PEEK:   state_in = not_empty ? ST_PEEK : ST_RESP;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_UP: begin
            if (up_stop) state_in = ST_RESP;
            else if (up_parent == '0) state_in = ST_PLACE;
            else state_in = ST_UP;
         end
         ST_DOWN_LOAD: begin
            if (count_ff == '0) state_in = ST_RESP;
            else if (count_ff == count_type'(1)) state_in = ST_PLACE;
            else state_in = ST_DOWN;
         end
         ST_DOWN: begin
            if (down_stop) state_in = ST_RESP;
            else if (ch_has_child) state_in = ST_DOWN;
            else state_in = ST_PLACE;
         end
         ST_PLACE: state_in = ST_RESP;
         ST_PEEK:  state_in = ST_RESP;
         ST_RESP:  state_in = slot_free ? ST_IDLE : ST_RESP;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      mem_req         = '0;
      mem_req.wdata   = moving_ff;
      mem_req.waddr   = pos_ff;
      pos_in          = pos_ff;
      moving_in       = moving_ff;
      count_in        = count_ff;
      res_in          = res_ff;
      status.idle     = 1'b0;
      status.done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            status.idle = 1'b1;
            unique case (req.operation)
               OP_REMOVE: mem_req.raddr_a = addr_type'(count_ff - count_type'(1));
               OP_PEEK:   mem_req.raddr_a = '0;
               default:   mem_req.raddr_a = parent_of(addr_type'(count_ff));
            endcase
            if (start) begin
               res_in           = '0;
               res_in.occupancy = OCC_W'(count_ff);
               unique case (req.operation)
                  OP_INSERT: begin
                     if (not_full) begin
                        count_in         = count_ff + count_type'(1);
                        res_in.ok        = 1'b1;
                        res_in.occupancy = OCC_W'(count_in);
                        pos_in           = addr_type'(count_ff);
                        moving_in.prio   = req.priority_req;
                        moving_in.tag    = req.payload;
                     end
                  end
                  OP_REMOVE: begin
                     if (not_empty) begin
                        count_in         = count_ff - count_type'(1);
                        res_in.ok        = 1'b1;
                        res_in.occupancy = OCC_W'(count_in);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_UP: begin
            mem_req.we      = 1'b1;
            mem_req.wdata   = up_stop ? moving_ff : rd_a;
            mem_req.raddr_a = parent_of(up_parent);
            if (!up_stop) pos_in = up_parent;
         end
         ST_DOWN_LOAD: begin
            moving_in       = rd_a;
            pos_in          = '0;
            mem_req.raddr_a = addr_type'(1);
            mem_req.raddr_b = addr_type'(2);
         end
         ST_DOWN: begin
            mem_req.we      = 1'b1;
            mem_req.wdata   = down_stop ? moving_ff : chosen;
            mem_req.raddr_a = ch_left[ADDR_W-1:0];
            mem_req.raddr_b = addr_type'(ch_left + cidx_type'(1));
            if (!down_stop) pos_in = chosen_idx;
         end
         ST_PLACE: begin
            mem_req.we = 1'b1;
         end
         ST_PEEK: begin
            res_in.top_priority = rd_a.prio;
            res_in.top_payload  = rd_a.tag;
            res_in.ok           = 1'b1;
         end
         ST_RESP: begin
            status.done = slot_free;
         end
         default: ;
      endcase
   end

   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      moving_ff <= moving_in;
      res_ff    <= res_in;
   end

endmodule
`default_nettype wire

// File: rtl/core/binary_max_heap_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one operation at a time; a sift moves one tree level per cycle,
//   bound by the single write port and registered read of the heap memory.
// Reset clears the entry count and control state; the heap memory is not
//   cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Binary max-heap of priority/tag entries held in one dual-read RAM, with
// insert, remove-top and peek operations over valid/ready channels.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue
   import bhpq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   eng_status_type status;
   rsp_type        result;
   mem_req_type    mem_req;
   entry_type      rd_a, rd_b;
   logic           start;
   logic           slot_free;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   // Take a new operation only while the sequencer is idle; the response
   // register lets it run while the previous result still waits.
   assign req_ready = status.idle;
   assign start     = req_valid && req_ready;

   // The response slot frees when empty or when its transfer completes.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   bhpq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .slot_free (slot_free),
      .status    (status),
      .result    (result),
      .mem_req   (mem_req),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   // Heap storage: one write and two reads per cycle, so sift-down sees both
   // children of a node at once.
   bhpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (mem_req.we),
      .wr_addr   (mem_req.waddr),
      .wr_data   (mem_req.wdata),
      .rd_addr_a (mem_req.raddr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (mem_req.raddr_b),
      .rd_data_b (rd_b)
   );

   // Load the response on completion, drop valid after its transfer, hold
   // otherwise.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: tb/binary_max_heap_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_test
// Self-checking bench for the heap priority queue. A shadow heap with the
// same sift and tie rules predicts every reply. A directed opening covers
// empty and unused-code cases and equal-priority ordering. Random fill and
// drain sweeps then push the heap to full and back to empty, with random
// gaps on both channels, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_test;
   import bhpq_pkg::*;

   // Operation code 3 has no name in the package; the block ignores it.
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1100;
   // Cycles without any transfer before the run is declared hung. The
   // longest legal quiet stretch is the receiver hold-off.
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned TAIL_CYCLES  = 20;

   // -------------------------------------------------------------------------
   // Shadow heap: mirrors the block's array, count and tie rules, and keeps
   // the replies still owed by the block in transfer order.
   // -------------------------------------------------------------------------
   class heap_shadow;
      entry_type   slots[CAPACITY];
      int unsigned held;
      rsp_type     owed_replies[$];
      int unsigned faults;

      function new();
         held   = 0;
         faults = 0;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         entry_type t;
         t        = slots[a];
         slots[a] = slots[b];
         slots[b] = t;
      endfunction

      // Equal priority passes the parent.
      function void sift_up(int unsigned child);
         int unsigned parent;
         while (child > 0) begin
            parent = (child - 1) / 2;
            if (slots[parent].prio > slots[child].prio) break;
            swap_slots(parent, child);
            child = parent;
         end
      endfunction

      // Right child wins only when strictly larger; stop when parent >= child.
      function void sift_down();
         int unsigned parent;
         int unsigned child;
         parent = 0;
         child  = 1;
         while (child < held) begin
            if (child + 1 < held && slots[child].prio < slots[child + 1].prio)
               child++;
            if (slots[parent].prio >= slots[child].prio) break;
            swap_slots(parent, child);
            parent = child;
            child  = 2 * parent + 1;
         end
      endfunction

      function void take_request(req_type r);
         rsp_type reply;
         reply = '0;
         case (r.operation)
            OP_INSERT: begin
               if (held < CAPACITY) begin
                  slots[held] = {r.priority_req, r.payload};
                  sift_up(held);
                  held++;
                  reply.ok = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (held > 0) begin
                  held--;
                  slots[0] = slots[held];
                  sift_down();
                  reply.ok = 1'b1;
               end
            end
            OP_PEEK: begin
               if (held > 0) begin
                  reply.top_priority = slots[0].prio;
                  reply.top_payload  = slots[0].tag;
                  reply.ok           = 1'b1;
               end
            end
            default: begin
            end
         endcase
         reply.occupancy = OCC_W'(held);
         owed_replies.push_back(reply);
      endfunction

      function void match_reply(rsp_type got);
         rsp_type want;
         if (owed_replies.size() == 0) begin
            $error("reply with no request pending: %p", got);
            faults++;
            return;
         end
         want = owed_replies.pop_front();
         if (got.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, got.ok);
            faults++;
         end
         if (got.top_priority !== want.top_priority) begin
            $error("top_priority: expected %0h, actual %0h",
                   want.top_priority, got.top_priority);
            faults++;
         end
         if (got.top_payload !== want.top_payload) begin
            $error("top_payload: expected %0h, actual %0h",
                   want.top_payload, got.top_payload);
            faults++;
         end
         if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d",
                   want.occupancy, got.occupancy);
            faults++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test and its channels. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   binary_max_heap_priority_queue u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   heap_shadow  shadow;
   // Receiver controls set by the stimulus process.
   bit          rx_steady;
   int unsigned rx_hold;
   // Sweep direction of the random part: grow toward full or shrink to empty.
   bit          filling;
   req_type     directed_q[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int unsigned pick_pause();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Mix wide values with narrow ranges so equal priorities are common and
   // the tie rules of both sifts decide which tag reaches the root.
   function automatic logic [PRIO_W-1:0] pick_priority();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return PRIO_W'($urandom);
      if (r < 75) return PRIO_W'($urandom_range(0, 7));
      if (r < 90) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return PRIO_W'(1);
            2:       return '1 - PRIO_W'(1);
            default: return '1;
         endcase
      end
      return PRIO_W'($urandom_range(16'hFFF0, 16'hFFFF));
   endfunction

   // Sweep between empty and full; linger a few items at either end so
   // refused inserts and removes show up in every sweep.
   function automatic req_type random_req();
      req_type     r;
      int unsigned roll;
      if (filling && shadow.held == CAPACITY && $urandom_range(0, 3) == 0)
         filling = 1'b0;
      else if (!filling && shadow.held == 0 && $urandom_range(0, 3) == 0)
         filling = 1'b1;
      roll           = $urandom_range(0, 99);
      r.priority_req = pick_priority();
      r.payload      = TAG_W'($urandom);
      if (roll < 62)      r.operation = filling ? OP_INSERT : OP_REMOVE;
      else if (roll < 80) r.operation = filling ? OP_REMOVE : OP_INSERT;
      else if (roll < 96) r.operation = OP_PEEK;
      else                r.operation = OP_UNUSED;
      return r;
   endfunction

   function automatic void add_directed(logic [1:0] op, logic [PRIO_W-1:0] p,
                                        logic [TAG_W-1:0] t);
      req_type r;
      r.operation    = op;
      r.priority_req = p;
      r.payload      = t;
      directed_q.push_back(r);
   endfunction

   // Offer one request and hold it until the transfer. Lower valid first for
   // a pause; when asked, also wait until every owed reply has come back.
   // valid gets a single assignment per time step: a drain always starts with
   // a pause, so valid is lowered before the wait.
   task automatic send_req(req_type r, int unsigned pause, bit drain_first);
      if (drain_first && pause == 0) pause = 1;
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
         while (drain_first && shadow.owed_replies.size() != 0)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      shadow.take_request(r);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: check each reply transfer, then decide the next ready. A
   // hold-off request is counted down here, independent of the sender.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) shadow.match_reply(rsp_data);
         if (rx_hold > 0) begin
            stall   = rx_hold;
            rx_hold = 0;
         end else if (stall == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
            stall = pick_pause();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when no transfer happens for too long.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("binary_max_heap_priority_queue_test NOT OK");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned pause;
      shadow    = new();
      rx_steady = 1'b0;
      rx_hold   = 0;
      filling   = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty heap: remove and peek fail, unused code is ignored.
      add_directed(OP_PEEK,   16'h0000, 16'h0000);
      add_directed(OP_REMOVE, 16'hFFFF, 16'hFFFF);
      add_directed(OP_UNUSED, 16'hFFFF, 16'hFFFF);
      // Field extremes, then an equal priority that must pass the root.
      add_directed(OP_INSERT, 16'h0000, 16'h0000);
      add_directed(OP_INSERT, 16'hFFFF, 16'hFFFF);
      add_directed(OP_PEEK,   16'h0000, 16'h0000);
      add_directed(OP_INSERT, 16'hFFFF, 16'h5A5A);
      add_directed(OP_PEEK,   16'hFFFF, 16'hFFFF);
      add_directed(OP_INSERT, 16'h8000, 16'h0001);
      add_directed(OP_INSERT, 16'h7FFF, 16'h8000);
      // Unused code on a non-empty heap leaves it alone.
      add_directed(OP_UNUSED, 16'hAAAA, 16'h5555);
      add_directed(OP_PEEK,   16'h5555, 16'hAAAA);
      // Drain to empty, peeking on the way.
      add_directed(OP_REMOVE, 16'h0000, 16'h0000);
      add_directed(OP_PEEK,   16'h0000, 16'h0000);
      add_directed(OP_REMOVE, 16'h0000, 16'h0000);
      add_directed(OP_REMOVE, 16'h0000, 16'h0000);
      add_directed(OP_PEEK,   16'h0000, 16'h0000);
      add_directed(OP_REMOVE, 16'h0000, 16'h0000);
      add_directed(OP_REMOVE, 16'h0000, 16'h0000);
      // Three equal priorities: on a tie in sift down the moved entry stays above its child.
      add_directed(OP_INSERT, 16'h0005, 16'h0001);
      add_directed(OP_INSERT, 16'h0005, 16'h0002);
      add_directed(OP_INSERT, 16'h0005, 16'h0003);
      add_directed(OP_REMOVE, 16'h0000, 16'h0000);
      add_directed(OP_PEEK,   16'h0000, 16'h0000);

      foreach (directed_q[i]) send_req(directed_q[i], pick_pause(), 1'b0);

      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         // Stall the receiver long enough for requests to back up.
         if (i == 400) rx_hold = HOLD_CYCLES;
         // Run a stretch with no gaps on either side.
         rx_steady = (i >= 800 && i < 900);
         pause     = rx_steady ? 0 : pick_pause();
         send_req(random_req(), pause, (i == 0 || i == 700));
      end
      req_valid <= 1'b0;

      // Wait for every owed reply, then let the block settle.
      while (shadow.owed_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (shadow.faults == 0)
         $display("binary_max_heap_priority_queue_test OK");
      else
         $display("binary_max_heap_priority_queue_test NOT OK");
      $finish;
   end

endmodule
